// ===== rtl/motor_feedback_frame_decoder_assert.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef MOTOR_FEEDBACK_FRAME_DECODER_ASSERT_SVH
`define MOTOR_FEEDBACK_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MFFD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MFFD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mffd_pkg.sv =====
// Package: constants and types of the motor feedback frame decoder.
`default_nettype none

package mffd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_LIMIT = 2'd3;

    localparam logic [3:0]  RST_NODE_ID      = 4'd1;
    localparam logic [23:0] RST_ANGLE_LIMIT  = 24'd819200;
    localparam logic [23:0] RST_SPEED_LIMIT  = 24'd1966080;
    localparam logic [23:0] RST_TORQUE_LIMIT = 24'd655360;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 144;

    localparam logic [6:0] MIN_FRAME_LEN = 7'd8;

    localparam int LIMIT_W     = 24;
    localparam int NOW_W       = 25;
    localparam int TOTAL_OUT_W = 48;
    localparam int ANG_CODE_W  = 16;
    localparam int SML_CODE_W  = 12;
    localparam int ANG_PROD_W  = ANG_CODE_W + LIMIT_W;
    localparam int SML_PROD_W  = SML_CODE_W + LIMIT_W;

    localparam logic [ANG_CODE_W-1:0] ANGLE_FULL = 16'hFFFF;
    localparam logic [SML_CODE_W-1:0] SMALL_FULL = 12'hFFF;

    localparam logic [TOTAL_OUT_W-1:0] SAT_POS     = 48'h7FFF_FFFF_FFFF;
    localparam logic [TOTAL_OUT_W-1:0] SAT_NEG_MAG = 48'h8000_0000_0000;

    typedef struct packed {
        logic [3:0] status;
        logic [7:0] driver_temp;
        logic [7:0] rotor_temp;
        logic       neg_angle;
        logic       neg_speed;
        logic       neg_torque;
        logic       neg_total;
    } t_side;

endpackage

`default_nettype wire

// ===== rtl/motor_feedback_frame_decoder.sv =====
// Top level: motor feedback frame filter, scaler and angle unwrapper.
//
//  channel   | direction | tdata fields (low bit up)                 | tuser
//  s_axis    | in        | frame_len, byte0 .. byte7                 | is_standard_id,
//            |           |                                           | is_data_frame
//  m_axis    | out       | motor_status, driver_temp, rotor_temp,    | -
//            |           | angle_now, speed_now, torque_now,         |
//            |           | angle_total                               |
//  cfg       | in        | write enable, index, data                 | -
//
//  One frame is taken per cycle until backpressure has filled every stage;
//  the NF = (TOTAL_WIDTH + 38) / 15 + 2 fold stages form the reciprocal
//  fold chain for the 65535 divide of the total.
//  Frames that fail the filter are taken and dropped at once.
//  Each stage holds under backpressure only while its successor is full, so
//  input stays open while a result waits in the output register, until every stage is full.
//  Reset is synchronous, active low, loads config defaults, clears unwrap state and valids.
`default_nettype none
`include "motor_feedback_frame_decoder_assert.svh"

module motor_feedback_frame_decoder #(
    parameter int TOTAL_WIDTH = 40
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [mffd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [mffd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             s_axis_tvalid,
    output      logic                             s_axis_tready,
    // frame_len[6:0], byte0[14:7], byte1 .. byte7 up to [70:63], zero pad [71]
    input  wire logic [mffd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // is_standard_id[0], is_data_frame[1]
    input  wire logic [mffd_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output      logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // motor_status[3:0], driver_temp[11:4], rotor_temp[19:12], angle_now[44:20],
    // speed_now[69:45], torque_now[94:70], angle_total[142:95], zero pad [143]
    output      logic [mffd_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import mffd_pkg::*;

    localparam int XW       = TOTAL_WIDTH + LIMIT_W;
    localparam int LO_W     = (TOTAL_WIDTH + 1) / 2;
    localparam int HI_W     = TOTAL_WIDTH - LO_W;
    localparam int NF       = (XW + 14) / 15 + 2;
    localparam int CW       = (XW > TOTAL_OUT_W) ? XW : TOTAL_OUT_W + 1;
    localparam int ST_IN    = 0;
    localparam int ST_UNW   = 1;
    localparam int ST_MUL   = 2;
    localparam int ST_TMUL  = 3;
    localparam int ST_SUM   = 4;
    localparam int ST_FOLD  = 5;
    localparam int ST_CORR  = ST_FOLD + NF;
    localparam int ST_OUT   = ST_CORR + 1;
    localparam int NS       = ST_OUT + 1;

    // configuration
    logic [3:0]         r_node_id;
    logic [LIMIT_W-1:0] r_angle_limit;
    logic [LIMIT_W-1:0] r_speed_limit;
    logic [LIMIT_W-1:0] r_torque_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id      <= RST_NODE_ID;
            r_angle_limit  <= RST_ANGLE_LIMIT;
            r_speed_limit  <= RST_SPEED_LIMIT;
            r_torque_limit <= RST_TORQUE_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NODE_ID:      r_node_id      <= i_cfg_data[3:0];
                CFG_ANGLE_LIMIT:  r_angle_limit  <= i_cfg_data;
                CFG_SPEED_LIMIT:  r_speed_limit  <= i_cfg_data;
                CFG_TORQUE_LIMIT: r_torque_limit <= i_cfg_data;
                default:          r_node_id      <= r_node_id;
            endcase
        end
    end

    // pipeline control
    logic [NS-1:0] r_v;
    logic [NS-1:0] w_rdy;
    logic          w_pass;
    logic          w_adv1;

    always_comb begin
        w_rdy[NS-1] = !r_v[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign s_axis_tready = w_rdy[ST_IN];
    assign m_axis_tvalid = r_v[ST_OUT];
    assign w_adv1        = r_v[ST_IN] && w_rdy[ST_UNW];

    assign w_pass = s_axis_tuser[0] && s_axis_tuser[1]
                 && (s_axis_tdata[6:0] >= MIN_FRAME_LEN)
                 && (s_axis_tdata[10:7] == r_node_id);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[ST_IN]) begin
                r_v[ST_IN] <= s_axis_tvalid && w_pass;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // input register: payload bytes 1 .. 5
    logic [39:0] r_in_bytes;

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_IN]) begin
            r_in_bytes <= s_axis_tdata[54:15];
        end
    end

    // unwrap and code magnitudes
    logic [15:0]        w_acode;
    logic [11:0]        w_scode;
    logic [11:0]        w_tcode;
    logic signed [17:0] w_twice_new;
    logic signed [17:0] w_twice_old;
    logic signed [17:0] w_diff;
    logic signed [17:0] w_step;
    logic signed [17:0] w_seed;
    logic [TOTAL_WIDTH-1:0] n_total;

    logic                   r_seeded;
    logic [15:0]            r_prev_code;
    logic [TOTAL_WIDTH-1:0] r_total;
    logic [15:0]            r_s1_ma;
    logic [11:0]            r_s1_ms;
    logic [11:0]            r_s1_mt;

    assign w_acode     = {r_in_bytes[7:0], r_in_bytes[15:8]};
    assign w_scode     = {r_in_bytes[23:16], r_in_bytes[31:28]};
    assign w_tcode     = {r_in_bytes[27:24], r_in_bytes[39:32]};
    assign w_twice_new = $signed({1'b0, w_acode, 1'b0});
    assign w_twice_old = $signed({1'b0, r_prev_code, 1'b0});
    assign w_diff      = w_twice_new - w_twice_old;
    assign w_seed      = w_twice_new - 18'sd65535;

    always_comb begin
        priority if (w_diff > 18'sd65535) begin
            w_step = w_diff - 18'sd131070;
        end else if (w_diff < -18'sd65535) begin
            w_step = w_diff + 18'sd131070;
        end else begin
            w_step = w_diff;
        end
        if (r_seeded) begin
            n_total = r_total + {{(TOTAL_WIDTH-18){w_step[17]}}, w_step};
        end else begin
            n_total = {{(TOTAL_WIDTH-18){w_seed[17]}}, w_seed};
        end
    end

    // r_total doubles as the unwrap stage's total: it only moves with that stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded    <= 1'b0;
            r_prev_code <= '0;
            r_total     <= '0;
        end else if (w_adv1) begin
            r_seeded    <= 1'b1;
            r_prev_code <= w_acode;
            r_total     <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_UNW]) begin
            r_s1_ma <= {w_acode[14:0] ^ {15{~w_acode[15]}}, 1'b1};
            r_s1_ms <= {w_scode[10:0] ^ {11{~w_scode[11]}}, 1'b1};
            r_s1_mt <= {w_tcode[10:0] ^ {11{~w_tcode[11]}}, 1'b1};
        end
    end

    // side fields travel with every stage
    t_side r_side    [NS];
    t_side w_side_in [NS];

    always_comb begin
        w_side_in[0].status      = s_axis_tdata[14:11];
        w_side_in[0].driver_temp = s_axis_tdata[62:55];
        w_side_in[0].rotor_temp  = s_axis_tdata[70:63];
        w_side_in[0].neg_angle   = 1'b0;
        w_side_in[0].neg_speed   = 1'b0;
        w_side_in[0].neg_torque  = 1'b0;
        w_side_in[0].neg_total   = 1'b0;
        for (int k = 1; k < NS; k++) begin
            w_side_in[k] = r_side[k-1];
        end
        w_side_in[ST_UNW].neg_angle  = ~w_acode[15];
        w_side_in[ST_UNW].neg_speed  = ~w_scode[11];
        w_side_in[ST_UNW].neg_torque = ~w_tcode[11];
        w_side_in[ST_MUL].neg_total  = r_total[TOTAL_WIDTH-1];
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (w_rdy[k]) begin
                r_side[k] <= w_side_in[k];
            end
        end
    end

    // products
    logic [ANG_PROD_W-1:0]  r_s2_pa, r_s3_pa, r_s4_pa;
    logic [SML_PROD_W-1:0]  r_s2_ps, r_s3_ps, r_s4_ps;
    logic [SML_PROD_W-1:0]  r_s2_pt, r_s3_pt, r_s4_pt;
    logic [TOTAL_WIDTH-1:0] r_s2_tmag;
    logic [HI_W+LIMIT_W-1:0] r_s3_ph;
    logic [LO_W+LIMIT_W-1:0] r_s3_pl;
    logic [XW-1:0]          r_s4_x;

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_MUL]) begin
            r_s2_pa   <= ANG_PROD_W'(r_s1_ma) * ANG_PROD_W'(r_angle_limit);
            r_s2_ps   <= SML_PROD_W'(r_s1_ms) * SML_PROD_W'(r_speed_limit);
            r_s2_pt   <= SML_PROD_W'(r_s1_mt) * SML_PROD_W'(r_torque_limit);
            r_s2_tmag <= r_total[TOTAL_WIDTH-1] ? -r_total : r_total;
        end
        if (w_rdy[ST_TMUL]) begin
            r_s3_pa <= r_s2_pa;
            r_s3_ps <= r_s2_ps;
            r_s3_pt <= r_s2_pt;
            r_s3_ph <= (HI_W+LIMIT_W)'(r_s2_tmag[TOTAL_WIDTH-1:LO_W])
                     * (HI_W+LIMIT_W)'(r_angle_limit);
            r_s3_pl <= (LO_W+LIMIT_W)'(r_s2_tmag[LO_W-1:0])
                     * (LO_W+LIMIT_W)'(r_angle_limit);
        end
        if (w_rdy[ST_SUM]) begin
            r_s4_pa <= r_s3_pa;
            r_s4_ps <= r_s3_ps;
            r_s4_pt <= r_s3_pt;
            r_s4_x  <= (XW'(r_s3_ph) << LO_W) + XW'(r_s3_pl);
        end
    end

    // divide by 2^n - 1: fold the high part into the remainder and the quotient
    logic [XW-1:0]         w_tot_q [NF+1], w_tot_r [NF+1], r_tot_q [NF], r_tot_r [NF];
    logic [ANG_PROD_W-1:0] w_ang_q [NF+1], w_ang_r [NF+1], r_ang_q [NF], r_ang_r [NF];
    logic [SML_PROD_W-1:0] w_spd_q [NF+1], w_spd_r [NF+1], r_spd_q [NF], r_spd_r [NF];
    logic [SML_PROD_W-1:0] w_trq_q [NF+1], w_trq_r [NF+1], r_trq_q [NF], r_trq_r [NF];

    always_comb begin
        w_tot_q[0] = '0;
        w_tot_r[0] = r_s4_x;
        w_ang_q[0] = '0;
        w_ang_r[0] = r_s4_pa;
        w_spd_q[0] = '0;
        w_spd_r[0] = r_s4_ps;
        w_trq_q[0] = '0;
        w_trq_r[0] = r_s4_pt;
        for (int f = 0; f < NF; f++) begin
            w_tot_q[f+1] = r_tot_q[f];
            w_tot_r[f+1] = r_tot_r[f];
            w_ang_q[f+1] = r_ang_q[f];
            w_ang_r[f+1] = r_ang_r[f];
            w_spd_q[f+1] = r_spd_q[f];
            w_spd_r[f+1] = r_spd_r[f];
            w_trq_q[f+1] = r_trq_q[f];
            w_trq_r[f+1] = r_trq_r[f];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int f = 0; f < NF; f++) begin
            if (w_rdy[ST_FOLD+f]) begin
                r_tot_q[f] <= w_tot_q[f] + (w_tot_r[f] >> ANG_CODE_W);
                r_tot_r[f] <= (w_tot_r[f] >> ANG_CODE_W)
                            + XW'(w_tot_r[f][ANG_CODE_W-1:0]);
                r_ang_q[f] <= w_ang_q[f] + (w_ang_r[f] >> ANG_CODE_W);
                r_ang_r[f] <= (w_ang_r[f] >> ANG_CODE_W)
                            + ANG_PROD_W'(w_ang_r[f][ANG_CODE_W-1:0]);
                r_spd_q[f] <= w_spd_q[f] + (w_spd_r[f] >> SML_CODE_W);
                r_spd_r[f] <= (w_spd_r[f] >> SML_CODE_W)
                            + SML_PROD_W'(w_spd_r[f][SML_CODE_W-1:0]);
                r_trq_q[f] <= w_trq_q[f] + (w_trq_r[f] >> SML_CODE_W);
                r_trq_r[f] <= (w_trq_r[f] >> SML_CODE_W)
                            + SML_PROD_W'(w_trq_r[f][SML_CODE_W-1:0]);
            end
        end
    end

    // last correction
    logic [XW-1:0]      r_c_tot;
    logic [LIMIT_W-1:0] r_c_ang;
    logic [LIMIT_W-1:0] r_c_spd;
    logic [LIMIT_W-1:0] r_c_trq;

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_CORR]) begin
            r_c_tot <= w_tot_q[NF] + XW'(w_tot_r[NF] >= XW'(ANGLE_FULL));
            r_c_ang <= LIMIT_W'(w_ang_q[NF]
                     + ANG_PROD_W'(w_ang_r[NF] >= ANG_PROD_W'(ANGLE_FULL)));
            r_c_spd <= LIMIT_W'(w_spd_q[NF]
                     + SML_PROD_W'(w_spd_r[NF] >= SML_PROD_W'(SMALL_FULL)));
            r_c_trq <= LIMIT_W'(w_trq_q[NF]
                     + SML_PROD_W'(w_trq_r[NF] >= SML_PROD_W'(SMALL_FULL)));
        end
    end

    // sign all results, saturate the total and hold the result
    logic [CW-1:0]          w_tot_ext;
    logic [TOTAL_OUT_W-1:0] n_o_tot;
    logic [NOW_W-1:0]       r_o_ang, r_o_spd, r_o_trq;
    logic [TOTAL_OUT_W-1:0] r_o_tot;

    assign w_tot_ext = CW'(r_c_tot);

    always_comb begin
        if (r_side[ST_CORR].neg_total) begin
            if (w_tot_ext > CW'(SAT_NEG_MAG)) begin
                n_o_tot = SAT_NEG_MAG;
            end else begin
                n_o_tot = TOTAL_OUT_W'(-w_tot_ext);
            end
        end else begin
            if (w_tot_ext > CW'(SAT_POS)) begin
                n_o_tot = SAT_POS;
            end else begin
                n_o_tot = TOTAL_OUT_W'(w_tot_ext);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_OUT]) begin
            r_o_ang <= r_side[ST_CORR].neg_angle  ? -{1'b0, r_c_ang} : {1'b0, r_c_ang};
            r_o_spd <= r_side[ST_CORR].neg_speed  ? -{1'b0, r_c_spd} : {1'b0, r_c_spd};
            r_o_trq <= r_side[ST_CORR].neg_torque ? -{1'b0, r_c_trq} : {1'b0, r_c_trq};
            r_o_tot <= n_o_tot;
        end
    end

    assign m_axis_tdata = {1'b0, r_o_tot, r_o_trq, r_o_spd, r_o_ang,
                           r_side[ST_OUT].rotor_temp, r_side[ST_OUT].driver_temp,
                           r_side[ST_OUT].status};

    `MFFD_ASSERT_NXT(a_seed_on_first, i_clk, i_rst_n, w_adv1, r_seeded,
        "unwrap state not seeded after a frame")
    `MFFD_ASSERT_NXT(a_unwrap_step, i_clk, i_rst_n, w_adv1 && r_seeded,
        TOTAL_WIDTH'(r_total - $past(r_total) + TOTAL_WIDTH'(65535)) <= TOTAL_WIDTH'(131070),
        "unwrapped step exceeds half the span")
    `MFFD_ASSERT_IMP(a_fold_done, i_clk, i_rst_n, r_v[ST_CORR-1],
        (r_tot_r[NF-1] <= XW'(ANGLE_FULL) + XW'(1))
        && (r_ang_r[NF-1] <= ANG_PROD_W'(ANGLE_FULL) + ANG_PROD_W'(1))
        && (r_spd_r[NF-1] <= SML_PROD_W'(SMALL_FULL) + SML_PROD_W'(1))
        && (r_trq_r[NF-1] <= SML_PROD_W'(SMALL_FULL) + SML_PROD_W'(1)),
        "fold chain left a remainder too large to correct")

endmodule

`default_nettype wire
